[sv/rme_pkg.sv]
// ----------------------------------------------------------------------------
// rme_pkg
// Shared constants, datapath opcodes and command struct for the RSA
// modular exponentiation block.
// ----------------------------------------------------------------------------
package rme_pkg;

   // operand width of message, modulus and exponents
   localparam int WORD_BITS = 32;
   // bits of the step counters, one count per operand bit
   localparam int CNT_BITS  = $clog2(WORD_BITS);
   // last value of a step counter
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   // configuration register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_MODULUS          = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PRIVATE_EXPONENT = 2'd2;

   // command codes carried in tuser
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE,
      OP_BASE,
      OP_MUL,
      OP_COMMIT,
      OP_OUTPUT
   } dp_op_type;

   // controller to datapath command
   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

endpackage

[sv/rme_datapath.sv]
// ----------------------------------------------------------------------------
// rme_datapath
// Configuration registers, bit-serial modular reduction and two shift-add
// modular multipliers sharing one multiplier-bit shift register.
// ----------------------------------------------------------------------------
module rme_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rme_pkg::dp_cmd_type                 cmd,
   input  logic                                command,
   input  logic [rme_pkg::WORD_BITS-1:0]       message,
   input  logic                                csr_we,
   input  logic [rme_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [rme_pkg::WORD_BITS-1:0]       csr_wdata,
   output logic [rme_pkg::WORD_BITS-1:0]       result
);

   localparam int W = rme_pkg::WORD_BITS;

   // one step of interleaved modular multiplication: r = (2r + bit*a) mod n
   function automatic logic [W-1:0] mod_step(input logic [W-1:0] r,
                                            input logic [W-1:0] a,
                                            input logic [W-1:0] n,
                                            input logic         bit_in);
      logic [W:0] dbl;
      logic [W:0] sum;
      dbl = {r, 1'b0};
      if (dbl >= {1'b0, n}) begin
         dbl = dbl - {1'b0, n};
      end
      sum = {1'b0, dbl[W-1:0]} + {1'b0, (bit_in ? a : {W{1'b0}})};
      if (sum >= {1'b0, n}) begin
         sum = sum - {1'b0, n};
      end
      return sum[W-1:0];
   endfunction

   logic [W-1:0] modulus_ff;
   logic [W-1:0] pub_exp_ff;
   logic [W-1:0] priv_exp_ff;
   logic [W-1:0] exp_sh_ff, exp_sh_in;
   logic [W-1:0] base_ff,   base_in;
   logic [W-1:0] acc_ff,    acc_in;
   logic [W-1:0] mbit_ff,   mbit_in;
   logic [W-1:0] pacc_ff,   pacc_in;
   logic [W-1:0] psq_ff,    psq_in;
   logic [W-1:0] result_ff, result_in;
   logic [W:0]   red_dbl;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= W'(1);
         pub_exp_ff  <= '0;
         priv_exp_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            rme_pkg::REG_MODULUS:          modulus_ff  <= csr_wdata;
            rme_pkg::REG_PUBLIC_EXPONENT:  pub_exp_ff  <= csr_wdata;
            rme_pkg::REG_PRIVATE_EXPONENT: priv_exp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // remainder step: shift in next message bit, one conditional subtract
   always_comb begin
      red_dbl = {psq_ff, mbit_ff[W-1]};
      if (red_dbl >= {1'b0, modulus_ff}) begin
         red_dbl = red_dbl - {1'b0, modulus_ff};
      end
   end

   // next values per datapath operation
   always_comb begin
      exp_sh_in = exp_sh_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      mbit_in   = mbit_ff;
      pacc_in   = pacc_ff;
      psq_in    = psq_ff;
      result_in = result_ff;
      unique case (cmd.op)
         rme_pkg::OP_LOAD: begin
            mbit_in   = message;
            psq_in    = '0;
            exp_sh_in = (command == rme_pkg::CMD_DECRYPT) ? priv_exp_ff : pub_exp_ff;
            acc_in    = (modulus_ff == W'(1)) ? '0 : W'(1);
         end
         rme_pkg::OP_REDUCE: begin
            psq_in  = red_dbl[W-1:0];
            mbit_in = {mbit_ff[W-2:0], 1'b0};
         end
         rme_pkg::OP_BASE: begin
            base_in = psq_ff;
            mbit_in = psq_ff;
            psq_in  = '0;
            pacc_in = '0;
         end
         rme_pkg::OP_MUL: begin
            mbit_in = {mbit_ff[W-2:0], 1'b0};
            pacc_in = mod_step(pacc_ff, acc_ff, modulus_ff, mbit_ff[W-1]);
            psq_in  = mod_step(psq_ff, base_ff, modulus_ff, mbit_ff[W-1]);
         end
         rme_pkg::OP_COMMIT: begin
            if (exp_sh_ff[0]) begin
               acc_in = pacc_ff;
            end
            base_in   = psq_ff;
            mbit_in   = psq_ff;
            exp_sh_in = {1'b0, exp_sh_ff[W-1:1]};
            pacc_in   = '0;
            psq_in    = '0;
         end
         rme_pkg::OP_OUTPUT: begin
            // a zero modulus yields zero
            result_in = (modulus_ff == '0) ? '0 : acc_ff;
         end
         default: ;
      endcase
   end

   // working registers
   always_ff @(posedge clock) begin
      exp_sh_ff <= exp_sh_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      mbit_ff   <= mbit_in;
      pacc_ff   <= pacc_in;
      psq_ff    <= psq_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

[sv/rme_ctrl.sv]
// ----------------------------------------------------------------------------
// rme_ctrl
// Sequencer for reduction, exponent-bit loop and result hand-off, plus the
// result channel valid flag.
// ----------------------------------------------------------------------------
module rme_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rme_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_BASE,
      ST_MUL,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic [rme_pkg::CNT_BITS-1:0]   cnt_ff,   cnt_in;
   logic [rme_pkg::CNT_BITS-1:0]   ecnt_ff,  ecnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ecnt_in      = ecnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = rme_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = rme_pkg::OP_LOAD;
               cnt_in   = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.op = rme_pkg::OP_REDUCE;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rme_pkg::CNT_LAST) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.op   = rme_pkg::OP_BASE;
            cnt_in   = '0;
            ecnt_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op = rme_pkg::OP_MUL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rme_pkg::CNT_LAST) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.op  = rme_pkg::OP_COMMIT;
            cnt_in  = '0;
            ecnt_in = ecnt_ff + 1'b1;
            if (ecnt_ff == rme_pkg::CNT_LAST) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.op       = rme_pkg::OP_OUTPUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/rsa_modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// Textbook RSA on single words: message^e or message^d modulo n.
// ----------------------------------------------------------------------------
// usage
//   req channel: tdata carries the message, tuser the command (encrypt uses
//   the public exponent, decrypt the private one). one transaction in gives
//   exactly one transaction out on the rsp channel, tdata = result.
//   csr port: csr_we writes csr_wdata into register csr_addr (0 modulus,
//   1 public exponent, 2 private exponent); other indexes are ignored.
//   write registers only while no transaction is in flight.
// sequence
//   an item runs bit-serial reduction of the message, a transfer step, then
//   a multiply and square step for each of the 32 exponent bits (multiply and
//   square run side by side in two shift-add units driven by one
//   multiplier-bit register), and a final load of the output register; a new
//   item is accepted only once the sequencer is idle again after that load.
// reset and stalls
//   reset clears the sequencer and sets modulus 1, exponents 0. a held
//   result waits in the output register while the next item is accepted and
//   worked on; only the final hand-off waits for rsp_tready.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rme_pkg::WORD_BITS-1:0]       req_tdata,   // [31:0] message
   input  logic [0:0]                          req_tuser,   // [0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rme_pkg::WORD_BITS-1:0]       rsp_tdata,   // [31:0] result
   input  logic                                csr_we,
   input  logic [rme_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [rme_pkg::WORD_BITS-1:0]       csr_wdata
);

   rme_pkg::dp_cmd_type dp_cmd;

   // sequencer
   rme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (dp_cmd)
   );

   // arithmetic and configuration
   rme_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .command   (req_tuser[0]),
      .message   (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .result    (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // block is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted transaction");

   // an output load always presents a result
   a_output_valid: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == rme_pkg::OP_OUTPUT) |=> rsp_tvalid)
      else $error("result loaded but rsp_tvalid low");

   // a new result appears only through an output load
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(dp_cmd.op == rme_pkg::OP_OUTPUT))
      else $error("rsp_tvalid rose without an output load");

   // load only issued on an accepted transaction
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == rme_pkg::OP_LOAD) |-> (req_tvalid && req_tready))
      else $error("operand load without an accepted transaction");
`endif

endmodule
